// ----- rtl/dda_line_color_rasterizer_defines.svh -----
// Assertion macros for the DDA line color rasterizer.
`ifndef DDA_LINE_COLOR_RASTERIZER_DEFINES_SVH
`define DDA_LINE_COLOR_RASTERIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define DLCR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define DLCR_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define DLCR_ASSERT(name, prop)
`define DLCR_ASSERT_NEVER(name, cond)
`endif
`endif

// ----- rtl/dlcr_pkg.sv -----
// Shared constants and types of the DDA line color rasterizer.
package dlcr_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned CHAN_W         = 8;
  localparam int unsigned NUM_CH         = 5;
  localparam int unsigned CH_IDX_W       = 3;

  // Division order: x, y, red, green, blue
  localparam logic [CH_IDX_W-1:0] CH_X = 3'd0;
  localparam logic [CH_IDX_W-1:0] CH_Y = 3'd1;
  localparam logic [CH_IDX_W-1:0] CH_R = 3'd2;
  localparam logic [CH_IDX_W-1:0] CH_G = 3'd3;
  localparam logic [CH_IDX_W-1:0] CH_B = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- rtl/dlcr_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module dlcr_div #(
  parameter int unsigned NUM_W = 28,
  parameter int unsigned DEN_W = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [DEN_W-1:0]    den_i,
  output logic [NUM_W-1:0]    quo_o,
  output dlcr_pkg::div_status_t status_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Numerator bits shift out of the top of quo_q as quotient bits enter below
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});
  assign rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign quo_o         = quo_q;
  assign status_o.busy = (cnt_q != '0);
  assign status_o.done = done_q;

endmodule

// ----- rtl/dda_line_color_rasterizer.sv -----
// Top level of the DDA line rasterizer with per-channel color interpolation.
//
// Input stream (s_axis): tuser is the item kind, 0 loads a segment, 1 advances.
// A load carries both endpoints and both colors in tdata and yields no output.
// It takes the major-axis length D and runs five divisions (x, y, red, green,
// blue delta over D) on one shared restoring divider, one quotient bit per
// cycle. tready stays low while the divisions run; the divider is NUM_W bits
// wide, NUM_W being the larger of COORD_BITS and 8 plus FRAC_BITS. A load
// with D = 0 starts no division and leaves the block idle.
// Each advance accepted while pixels remain puts one pixel into the output
// register; advances are taken one per cycle unless a held pixel stalls. tlast
// marks the last of the D pixels. Advances with no pixel left are taken, dropped.
// Output stream (m_axis): the output register holds its pixel while tready is
// low; a new request is still taken in the cycle the held pixel drains.
// Reset clears all accumulators, steps and the pixel count; the block comes
// out of reset idle and ready.
`include "dda_line_color_rasterizer_defines.svh"

module dda_line_color_rasterizer #(
  parameter int unsigned COORD_BITS = dlcr_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dlcr_pkg::FRAC_BITS_DEF,
  localparam int unsigned IN_BITS   = 4 * COORD_BITS + 6 * dlcr_pkg::CHAN_W,
  localparam int unsigned IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS  = 2 * COORD_BITS + 3 * dlcr_pkg::CHAN_W,
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // start_x, start_y, end_x, end_y, start_red, start_green, start_blue,
  // end_red, end_green, end_blue
  input  logic [IN_W-1:0] s_axis_tdata_i,
  // kind
  input  logic            s_axis_tuser_i,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  // pixel_x, pixel_y, pixel_color
  output logic [OUT_W-1:0] m_axis_tdata_o,
  // last_pixel
  output logic            m_axis_tlast_o
);

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned CW     = dlcr_pkg::CHAN_W;
  localparam int unsigned MAG_W  = (CB > CW) ? CB : CW;
  localparam int unsigned NUM_W  = MAG_W + FRAC_BITS;
  localparam int unsigned ACC_W  = CB + FRAC_BITS;
  localparam int unsigned SXY_W  = FRAC_BITS + 2;
  localparam int unsigned COL_W  = FRAC_BITS + CW + 1;
  localparam int unsigned CNT_W  = CB + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  localparam logic [ACC_W:0] HALF_ACC = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

  // Round half away from zero and keep the low CB bits
  function automatic logic [CB-1:0] round_pos(input logic [ACC_W-1:0] v);
    logic           neg;
    logic [ACC_W:0] ext;
    logic [ACC_W:0] mag;
    logic [ACC_W:0] sum;
    logic [CB:0]    rnd;
    logic [CB:0]    res;
    neg = v[ACC_W-1];
    ext = {neg, v};
    mag = neg ? (~ext + (ACC_W + 1)'(1)) : ext;
    sum = mag + HALF_ACC;
    rnd = sum[ACC_W:FRAC_BITS];
    res = neg ? (~rnd + (CB + 1)'(1)) : rnd;
    return res[CB-1:0];
  endfunction

  function automatic logic [CW-1:0] chan(input logic [COL_W-1:0] v);
    return v[COL_W-1] ? '0 : v[FRAC_BITS+CW-1:FRAC_BITS];
  endfunction

  // Input fields
  logic [CB-1:0] start_x, start_y, end_x, end_y;
  logic [CW-1:0] start_red, start_green, start_blue;
  logic [CW-1:0] end_red, end_green, end_blue;

  assign start_x     = s_axis_tdata_i[CB-1:0];
  assign start_y     = s_axis_tdata_i[2*CB-1:CB];
  assign end_x       = s_axis_tdata_i[3*CB-1:2*CB];
  assign end_y       = s_axis_tdata_i[4*CB-1:3*CB];
  assign start_red   = s_axis_tdata_i[4*CB+CW-1:4*CB];
  assign start_green = s_axis_tdata_i[4*CB+2*CW-1:4*CB+CW];
  assign start_blue  = s_axis_tdata_i[4*CB+3*CW-1:4*CB+2*CW];
  assign end_red     = s_axis_tdata_i[4*CB+4*CW-1:4*CB+3*CW];
  assign end_green   = s_axis_tdata_i[4*CB+5*CW-1:4*CB+4*CW];
  assign end_blue    = s_axis_tdata_i[4*CB+6*CW-1:4*CB+5*CW];

  // Control and state
  logic                        state_q, state_d;
  logic [dlcr_pkg::CH_IDX_W-1:0] idx_q, idx_d;
  logic                        go_q, go_d;
  logic [CNT_W-1:0]            pixels_left_q, pixels_left_d;
  logic                        out_valid_q, out_valid_d;

  logic [ACC_W-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COL_W-1:0] cur_red_q, cur_red_d, cur_green_q, cur_green_d;
  logic [COL_W-1:0] cur_blue_q, cur_blue_d;
  logic [SXY_W-1:0] step_x_q, step_x_d, step_y_q, step_y_d;
  logic [COL_W-1:0] step_red_q, step_red_d, step_green_q, step_green_d;
  logic [COL_W-1:0] step_blue_q, step_blue_d;

  logic [MAG_W-1:0]            mag_q [dlcr_pkg::NUM_CH];
  logic [dlcr_pkg::NUM_CH-1:0] sign_q;
  logic [CB-1:0]               den_q;

  logic [OUT_BITS-1:0] out_data_q;
  logic                out_last_q;

  // Load datapath
  logic [CB:0]   dx, dy;
  logic [CB-1:0] ax, ay, dlen;
  logic [CW:0]   dr, dg, db;
  logic [CW-1:0] ar, ag, ab;

  assign dx   = {end_x[CB-1], end_x} - {start_x[CB-1], start_x};
  assign dy   = {end_y[CB-1], end_y} - {start_y[CB-1], start_y};
  assign ax   = dx[CB] ? (~dx[CB-1:0] + CB'(1)) : dx[CB-1:0];
  assign ay   = dy[CB] ? (~dy[CB-1:0] + CB'(1)) : dy[CB-1:0];
  assign dlen = (ax > ay) ? ax : ay;
  assign dr   = {1'b0, end_red} - {1'b0, start_red};
  assign dg   = {1'b0, end_green} - {1'b0, start_green};
  assign db   = {1'b0, end_blue} - {1'b0, start_blue};
  assign ar   = dr[CW] ? (~dr[CW-1:0] + CW'(1)) : dr[CW-1:0];
  assign ag   = dg[CW] ? (~dg[CW-1:0] + CW'(1)) : dg[CW-1:0];
  assign ab   = db[CW] ? (~db[CW-1:0] + CW'(1)) : db[CW-1:0];

  logic accept, load_acc, adv_acc, emit;

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign load_acc = accept && !s_axis_tuser_i;
  assign adv_acc  = accept && s_axis_tuser_i;
  assign emit     = adv_acc && (pixels_left_q != '0);

  // Shared divider
  logic [NUM_W-1:0]      div_quo;
  dlcr_pkg::div_status_t div_stat;
  logic [NUM_W-1:0]      div_num;
  logic [SXY_W-1:0]      q_xy;
  logic [COL_W-1:0]      q_col;
  logic                  q_neg;

  assign div_num = {mag_q[idx_q], {FRAC_BITS{1'b0}}};

  dlcr_div #(
    .NUM_W (NUM_W),
    .DEN_W (CB)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (go_q),
    .num_i    (div_num),
    .den_i    (den_q),
    .quo_o    (div_quo),
    .status_o (div_stat)
  );

  // A coordinate quotient is at most one, a channel quotient below 2^CW
  assign q_neg = sign_q[idx_q];
  assign q_xy  = {1'b0, div_quo[FRAC_BITS:0]};
  assign q_col = {1'b0, div_quo[FRAC_BITS+CW-1:0]};

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    go_d          = 1'b0;
    pixels_left_d = pixels_left_q;
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    cur_red_d     = cur_red_q;
    cur_green_d   = cur_green_q;
    cur_blue_d    = cur_blue_q;
    step_x_d      = step_x_q;
    step_y_d      = step_y_q;
    step_red_d    = step_red_q;
    step_green_d  = step_green_q;
    step_blue_d   = step_blue_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    if (load_acc) begin
      cur_x_d       = {start_x, {FRAC_BITS{1'b0}}};
      cur_y_d       = {start_y, {FRAC_BITS{1'b0}}};
      cur_red_d     = {1'b0, start_red, {FRAC_BITS{1'b0}}};
      cur_green_d   = {1'b0, start_green, {FRAC_BITS{1'b0}}};
      cur_blue_d    = {1'b0, start_blue, {FRAC_BITS{1'b0}}};
      step_x_d      = '0;
      step_y_d      = '0;
      step_red_d    = '0;
      step_green_d  = '0;
      step_blue_d   = '0;
      pixels_left_d = {1'b0, dlen};
      idx_d         = dlcr_pkg::CH_X;
      if (dlen != '0) begin
        state_d = ST_DIV;
        go_d    = 1'b1;
      end
    end else if (emit) begin
      out_valid_d   = 1'b1;
      cur_x_d       = cur_x_q + {{(ACC_W-SXY_W){step_x_q[SXY_W-1]}}, step_x_q};
      cur_y_d       = cur_y_q + {{(ACC_W-SXY_W){step_y_q[SXY_W-1]}}, step_y_q};
      cur_red_d     = cur_red_q + step_red_q;
      cur_green_d   = cur_green_q + step_green_q;
      cur_blue_d    = cur_blue_q + step_blue_q;
      pixels_left_d = pixels_left_q - CNT_W'(1);
    end
    if (div_stat.done) begin
      unique case (idx_q)
        dlcr_pkg::CH_X: step_x_d     = q_neg ? (~q_xy + SXY_W'(1)) : q_xy;
        dlcr_pkg::CH_Y: step_y_d     = q_neg ? (~q_xy + SXY_W'(1)) : q_xy;
        dlcr_pkg::CH_R: step_red_d   = q_neg ? (~q_col + COL_W'(1)) : q_col;
        dlcr_pkg::CH_G: step_green_d = q_neg ? (~q_col + COL_W'(1)) : q_col;
        default:        step_blue_d  = q_neg ? (~q_col + COL_W'(1)) : q_col;
      endcase
      if (idx_q == dlcr_pkg::CH_B) begin
        state_d = ST_IDLE;
      end else begin
        idx_d = idx_q + dlcr_pkg::CH_IDX_W'(1);
        go_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      idx_q         <= dlcr_pkg::CH_X;
      go_q          <= 1'b0;
      pixels_left_q <= '0;
      out_valid_q   <= 1'b0;
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      cur_red_q     <= '0;
      cur_green_q   <= '0;
      cur_blue_q    <= '0;
      step_x_q      <= '0;
      step_y_q      <= '0;
      step_red_q    <= '0;
      step_green_q  <= '0;
      step_blue_q   <= '0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      go_q          <= go_d;
      pixels_left_q <= pixels_left_d;
      out_valid_q   <= out_valid_d;
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      cur_red_q     <= cur_red_d;
      cur_green_q   <= cur_green_d;
      cur_blue_q    <= cur_blue_d;
      step_x_q      <= step_x_d;
      step_y_q      <= step_y_d;
      step_red_q    <= step_red_d;
      step_green_q  <= step_green_d;
      step_blue_q   <= step_blue_d;
    end
  end

  // Delta magnitudes and signs, held for the division pass
  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      mag_q[dlcr_pkg::CH_X] <= MAG_W'(ax);
      mag_q[dlcr_pkg::CH_Y] <= MAG_W'(ay);
      mag_q[dlcr_pkg::CH_R] <= MAG_W'(ar);
      mag_q[dlcr_pkg::CH_G] <= MAG_W'(ag);
      mag_q[dlcr_pkg::CH_B] <= MAG_W'(ab);
      sign_q <= {db[CW], dg[CW], dr[CW], dy[CB], dx[CB]};
      den_q  <= dlen;
    end
  end

  // Output register, loaded from the accumulators before they advance
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {chan(cur_red_q), chan(cur_green_q), chan(cur_blue_q),
                     round_pos(cur_y_q), round_pos(cur_x_q)};
      out_last_q <= (pixels_left_q == CNT_W'(1));
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'(out_data_q);
  assign m_axis_tlast_o  = out_last_q;

  `DLCR_ASSERT(a_div_idle, (state_q == ST_IDLE) |-> !div_stat.busy)
  `DLCR_ASSERT_NEVER(a_done_outside_div, div_stat.done && (state_q != ST_DIV))
  `DLCR_ASSERT(a_div_keeps_count,
      (state_q == ST_DIV) ##1 (state_q == ST_IDLE) |-> (pixels_left_q != '0))
  `DLCR_ASSERT(a_div_blocks_input, (state_q == ST_DIV) |-> !s_axis_tready_o)

endmodule
